>>> rtl/ihtf_pkg.sv
package ihtf_pkg;

  localparam int VAL_W    = 32;
  localparam int DIG_W    = 4;
  localparam int NDIG_DEC = 10;
  localparam int NDIG_HEX = VAL_W / DIG_W;
  localparam int BCD_W    = NDIG_DEC * DIG_W;
  localparam int CNT_W    = $clog2(VAL_W);
  localparam int NDIG_W   = $clog2(NDIG_DEC + 1);
  localparam int LEN_W    = 6;

  localparam logic FUNC_DEC = 1'b0;
  localparam logic FUNC_HEX = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic             width_given;
    logic [LEN_W-1:0] field_width;
    logic             precision_given;
    logic [LEN_W-1:0] precision;
  } fmt_t;

  typedef struct packed {
    logic [BCD_W-1:0]  digits;   // most significant digit in the top nibble
    logic [NDIG_W-1:0] ndig;
    logic              neg;
  } conv_res_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_DABBLE,
    C_NORM
  } conv_state_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_WAIT,
    E_ZCNT,
    E_SCNT,
    E_SPACE,
    E_SIGN,
    E_ZERO,
    E_DIGIT
  } emit_state_t;

  // shift-and-add-3 correction for one BCD digit
  function automatic logic [DIG_W-1:0] dabble_adj(input logic [DIG_W-1:0] d);
    dabble_adj = (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

  function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d);
    case (d)
      4'h0: digit_char = 8'h30;
      4'h1: digit_char = 8'h31;
      4'h2: digit_char = 8'h32;
      4'h3: digit_char = 8'h33;
      4'h4: digit_char = 8'h34;
      4'h5: digit_char = 8'h35;
      4'h6: digit_char = 8'h36;
      4'h7: digit_char = 8'h37;
      4'h8: digit_char = 8'h38;
      4'h9: digit_char = 8'h39;
      4'ha: digit_char = 8'h61;
      4'hb: digit_char = 8'h62;
      4'hc: digit_char = 8'h63;
      4'hd: digit_char = 8'h64;
      4'he: digit_char = 8'h65;
      default: digit_char = 8'h66;
    endcase
  endfunction

endpackage

>>> rtl/ihtf_conv.sv
module ihtf_conv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [ihtf_pkg::VAL_W-1:0]    value,
  input  logic                          func,
  output logic                          done,
  output ihtf_pkg::conv_res_t           res
);

  ihtf_pkg::conv_state_t state, state_next;

  logic [ihtf_pkg::VAL_W-1:0]  mag;
  logic [ihtf_pkg::VAL_W-1:0]  mag_abs;
  logic [ihtf_pkg::BCD_W-1:0]  bcd;
  logic [ihtf_pkg::BCD_W-1:0]  bcd_adj;
  logic [ihtf_pkg::CNT_W-1:0]  bitcnt;
  logic [ihtf_pkg::NDIG_W-1:0] ndig;
  logic                        neg;
  logic                        neg_in;
  logic                        shift_ok;

  assign neg_in  = (func == ihtf_pkg::FUNC_DEC) && value[ihtf_pkg::VAL_W-1];
  assign mag_abs = neg_in ? ({ihtf_pkg::VAL_W{1'b0}} - value) : value;

  // leading zero digit can be dropped while more than one digit remains
  assign shift_ok = (ndig > ihtf_pkg::NDIG_W'(1)) &&
                    (bcd[ihtf_pkg::BCD_W-1 -: ihtf_pkg::DIG_W] == '0);

  always_comb begin
    for (int i = 0; i < ihtf_pkg::NDIG_DEC; i++) begin
      bcd_adj[i*ihtf_pkg::DIG_W +: ihtf_pkg::DIG_W] =
        ihtf_pkg::dabble_adj(bcd[i*ihtf_pkg::DIG_W +: ihtf_pkg::DIG_W]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ihtf_pkg::C_IDLE: begin
        if (go) begin
          state_next = (func == ihtf_pkg::FUNC_HEX) ? ihtf_pkg::C_NORM : ihtf_pkg::C_DABBLE;
        end
      end
      ihtf_pkg::C_DABBLE: begin
        if (bitcnt == ihtf_pkg::CNT_W'(ihtf_pkg::VAL_W - 1)) begin
          state_next = ihtf_pkg::C_NORM;
        end
      end
      ihtf_pkg::C_NORM: begin
        if (!shift_ok) begin
          state_next = ihtf_pkg::C_IDLE;
        end
      end
      default: state_next = ihtf_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    done = (state == ihtf_pkg::C_NORM) && !shift_ok;
    res.digits = bcd;
    res.ndig   = ndig;
    res.neg    = neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ihtf_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ihtf_pkg::C_IDLE: begin
        if (go) begin
          neg    <= neg_in;
          bitcnt <= '0;
          mag    <= mag_abs;
          if (func == ihtf_pkg::FUNC_HEX) begin
            bcd  <= {value, {(ihtf_pkg::BCD_W - ihtf_pkg::VAL_W){1'b0}}};
            ndig <= ihtf_pkg::NDIG_W'(ihtf_pkg::NDIG_HEX);
          end else begin
            bcd  <= '0;
            ndig <= ihtf_pkg::NDIG_W'(ihtf_pkg::NDIG_DEC);
          end
        end
      end
      ihtf_pkg::C_DABBLE: begin
        bcd    <= {bcd_adj[ihtf_pkg::BCD_W-2:0], mag[ihtf_pkg::VAL_W-1]};
        mag    <= {mag[ihtf_pkg::VAL_W-2:0], 1'b0};
        bitcnt <= bitcnt + ihtf_pkg::CNT_W'(1);
      end
      ihtf_pkg::C_NORM: begin
        if (shift_ok) begin
          bcd  <= {bcd[ihtf_pkg::BCD_W-ihtf_pkg::DIG_W-1:0], {ihtf_pkg::DIG_W{1'b0}}};
          ndig <= ndig - ihtf_pkg::NDIG_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/ihtf_emit.sv
module ihtf_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ihtf_pkg::fmt_t      fmt,
  input  logic                conv_done,
  input  ihtf_pkg::conv_res_t res,
  output logic                busy,
  output logic                strobe,
  output logic [7:0]          char_out,
  output logic                last
);

  ihtf_pkg::emit_state_t state, state_next;
  ihtf_pkg::emit_state_t after_space, after_sign;

  ihtf_pkg::fmt_t              fmt_q;
  logic [ihtf_pkg::BCD_W-1:0]  digs;
  logic [ihtf_pkg::NDIG_W-1:0] ndig;
  logic                        neg;
  logic [ihtf_pkg::LEN_W-1:0]  zer, zer_calc;
  logic [ihtf_pkg::LEN_W-1:0]  spc, spc_calc;
  logic [ihtf_pkg::LEN_W:0]    body, spc_diff;
  logic [ihtf_pkg::LEN_W-1:0]  ndig_ext;

  logic       strobe_next;
  logic [7:0] char_next;
  logic       last_next;

  assign ndig_ext = ihtf_pkg::LEN_W'(ndig);
  assign zer_calc = (fmt_q.precision_given && (fmt_q.precision > ndig_ext)) ?
                    fmt_q.precision - ndig_ext : '0;
  assign body     = {{ihtf_pkg::LEN_W{1'b0}}, neg} + {1'b0, zer} + {1'b0, ndig_ext};
  assign spc_diff = {1'b0, fmt_q.field_width} - body;
  assign spc_calc = (fmt_q.width_given && ({1'b0, fmt_q.field_width} > body)) ?
                    spc_diff[ihtf_pkg::LEN_W-1:0] : '0;

  assign after_sign  = (zer != '0) ? ihtf_pkg::E_ZERO : ihtf_pkg::E_DIGIT;
  assign after_space = neg ? ihtf_pkg::E_SIGN : after_sign;

  always_comb begin
    state_next = state;
    case (state)
      ihtf_pkg::E_IDLE:  if (start) state_next = ihtf_pkg::E_WAIT;
      ihtf_pkg::E_WAIT:  if (conv_done) state_next = ihtf_pkg::E_ZCNT;
      ihtf_pkg::E_ZCNT:  state_next = ihtf_pkg::E_SCNT;
      ihtf_pkg::E_SCNT:  state_next = (spc_calc != '0) ? ihtf_pkg::E_SPACE : after_space;
      ihtf_pkg::E_SPACE: begin
        if (spc <= ihtf_pkg::LEN_W'(1)) state_next = after_space;
      end
      ihtf_pkg::E_SIGN:  state_next = after_sign;
      ihtf_pkg::E_ZERO: begin
        if (zer <= ihtf_pkg::LEN_W'(1)) state_next = ihtf_pkg::E_DIGIT;
      end
      ihtf_pkg::E_DIGIT: begin
        if (ndig <= ihtf_pkg::NDIG_W'(1)) state_next = ihtf_pkg::E_IDLE;
      end
      default: state_next = ihtf_pkg::E_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != ihtf_pkg::E_IDLE);
    strobe_next = 1'b0;
    char_next   = ihtf_pkg::CH_SPACE;
    last_next   = 1'b0;
    case (state)
      ihtf_pkg::E_SPACE: begin
        strobe_next = 1'b1;
        char_next   = ihtf_pkg::CH_SPACE;
      end
      ihtf_pkg::E_SIGN: begin
        strobe_next = 1'b1;
        char_next   = ihtf_pkg::CH_MINUS;
      end
      ihtf_pkg::E_ZERO: begin
        strobe_next = 1'b1;
        char_next   = ihtf_pkg::CH_ZERO;
      end
      ihtf_pkg::E_DIGIT: begin
        strobe_next = 1'b1;
        char_next   = ihtf_pkg::digit_char(digs[ihtf_pkg::BCD_W-1 -: ihtf_pkg::DIG_W]);
        last_next   = (ndig <= ihtf_pkg::NDIG_W'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ihtf_pkg::E_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    char_out <= char_next;
    last     <= last_next;
    case (state)
      ihtf_pkg::E_IDLE:  if (start) fmt_q <= fmt;
      ihtf_pkg::E_WAIT: begin
        if (conv_done) begin
          digs <= res.digits;
          ndig <= res.ndig;
          neg  <= res.neg;
        end
      end
      ihtf_pkg::E_ZCNT:  zer <= zer_calc;
      ihtf_pkg::E_SCNT:  spc <= spc_calc;
      ihtf_pkg::E_SPACE: spc <= spc - ihtf_pkg::LEN_W'(1);
      ihtf_pkg::E_ZERO:  zer <= zer - ihtf_pkg::LEN_W'(1);
      ihtf_pkg::E_DIGIT: begin
        digs <= {digs[ihtf_pkg::BCD_W-ihtf_pkg::DIG_W-1:0], {ihtf_pkg::DIG_W{1'b0}}};
        ndig <= ndig - ihtf_pkg::NDIG_W'(1);
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/int_hex_text_formatter.sv
// Integer to text formatter: signed decimal or lower-case hex, with optional
// minimum field width (space padded) and precision (zero padded).
//
// Request channel: a transfer happens on a rising edge with start high and
// busy low; value, func, width_given, field_width, precision_given and
// precision are sampled then. busy stays high until the last character of
// the request has been issued to the output register.
//
// Result channel: one ASCII character per cycle on char_out, marked by
// strobe for exactly one cycle; last flags the final character. The
// receiver cannot stall, characters are never held.
//
// Decimal runs the value through the shift-and-add-3 converter (one
// value bit per cycle), hex loads its nibbles directly. Leading zero digits
// are then stripped one per cycle (up to 9), the setup states E_ZCNT and
// E_SCNT size the padding, and characters stream at one per cycle. A
// request produces 1..64 characters.
//
// Reset (rst, synchronous) returns both sequencers to idle and drops strobe.
module int_hex_text_formatter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ihtf_pkg::VAL_W-1:0]  value,
  input  logic                               func,
  input  logic                               width_given,
  input  logic [ihtf_pkg::LEN_W-1:0]         field_width,
  input  logic                               precision_given,
  input  logic [ihtf_pkg::LEN_W-1:0]         precision,
  output logic                               strobe,
  output logic [7:0]                         char_out,
  output logic                               last
);

  logic                accept;
  logic                conv_done;
  ihtf_pkg::conv_res_t conv_res;
  ihtf_pkg::fmt_t      fmt;

  // the emit sequencer stays busy from the transfer through the last char,
  // so it also covers the conversion phase
  assign accept = start && !busy;

  assign fmt.width_given     = width_given;
  assign fmt.field_width     = field_width;
  assign fmt.precision_given = precision_given;
  assign fmt.precision       = precision;

  // digit generator: bit-serial binary to BCD (decimal) or direct nibble load (hex), then leading zero strip
  ihtf_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .go    (accept),
    .value (value),
    .func  (func),
    .done  (conv_done),
    .res   (conv_res)
  );

  // padding and character sequencer
  ihtf_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .fmt       (fmt),
    .conv_done (conv_done),
    .res       (conv_res),
    .busy      (busy),
    .strobe    (strobe),
    .char_out  (char_out),
    .last      (last)
  );

endmodule
